/* sv/rau_pkg.sv */
// ---------------------------------------------------------------------------
// rau_pkg
// shared types, operation codes and command/status structs
// ---------------------------------------------------------------------------
package rau_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH + 1);

    typedef enum logic [2:0] {
        FUNC_ADD   = 3'd0,
        FUNC_SUB   = 3'd1,
        FUNC_MUL   = 3'd2,
        FUNC_DIV   = 3'd3,
        FUNC_CANON = 3'd4,
        FUNC_QUICK = 3'd5,
        FUNC_NEG   = 3'd6,
        FUNC_NONE  = 3'd7
    } func_t;

    // datapath operations requested by the controller
    typedef enum logic [3:0] {
        OP_IDLE   = 4'd0,
        OP_LOAD   = 4'd1,  // capture operands
        OP_MUL_A  = 4'd2,  // first product into x
        OP_MUL_B  = 4'd3,  // second product, combine or into y
        OP_MUL_C  = 4'd4,  // denominator product for add/sub
        OP_PREP   = 4'd5,  // zero checks, magnitudes, gcd setup
        OP_GCD    = 4'd6,  // one step of binary gcd
        OP_DIVS   = 4'd7,  // one restoring division step (both quotients)
        OP_FIX    = 4'd8   // apply signs, make denominator positive
    } op_t;

    typedef struct packed {
        op_t  op;
        logic div_init;
    } rau_cmd_t;

    typedef struct packed {
        logic gcd_done;
        logic div_done;
        logic early;     // result already final (zero or quick case)
        logic two_mul;   // add/sub with unequal denominators
        logic one_mul;   // mul or div
    } rau_sts_t;

endpackage

/* sv/rational_arithmetic_unit.sv */
// ---------------------------------------------------------------------------
// rational_arithmetic_unit
// reduced rational add, sub, mul, div, canonicalize and negate
// ---------------------------------------------------------------------------
// sequence: zero, quick and unused cases go from the check state straight to
// output; mul/div then run S_MULA and S_MULB, add/sub with unequal
// denominators also S_MULC, then prep, binary gcd steps until both operands
// match, the serial divide, sign fix and output; one request at a time, and
// the next request can be taken from the cycle after the result handshake
// reset: asynchronous active-low clears the sequencer and datapath registers
// ---------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func[2:0], left_numer[34:3], left_denom[66:35], right_numer[98:67],
    // right_denom[130:99], zero fill to 136
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_numer[31:0], result_denom[63:32]
    output logic [63:0]  m_tdata
);

    rau_cmd_t cmd;
    rau_sts_t sts;
    logic     busy;
    logic     in_fire, out_fire;
    logic [31:0] rn, rd;

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign m_tdata  = {rd, rn};

    rau_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .sts(sts), .cmd(cmd), .busy(busy), .out_valid(m_tvalid)
    );

    rau_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .func(s_tdata[2:0]),
        .left_numer(s_tdata[34:3]), .left_denom(s_tdata[66:35]),
        .right_numer(s_tdata[98:67]), .right_denom(s_tdata[130:99]),
        .result_numer(rn), .result_denom(rd)
    );

`ifndef ASSERT_OFF
    // result held while waiting
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");
    // no new request while a result is pending
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while result pending");
`endif

endmodule

/* sv/rau_datapath.sv */
// ---------------------------------------------------------------------------
// rau_datapath
// operand registers, shared multiplier, binary gcd and serial divider
// ---------------------------------------------------------------------------
module rau_datapath
    import rau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rau_cmd_t    cmd,
    output rau_sts_t    sts,
    input  logic [2:0]  func,
    input  logic [31:0] left_numer,
    input  logic [31:0] left_denom,
    input  logic [31:0] right_numer,
    input  logic [31:0] right_denom,
    output logic [31:0] result_numer,
    output logic [31:0] result_denom
);

    logic [WIDTH-1:0] nl_reg, dl_reg, nr_reg, dr_reg;
    func_t            f_reg;
    logic [WIDTH-1:0] x_reg, y_reg;       // numerator, denominator before reduction
    logic [WIDTH-1:0] ga_reg, gb_reg;     // gcd operands
    logic [CNT_W-1:0] sh_reg;             // common power of two
    logic [WIDTH-1:0] g_reg;
    logic [WIDTH-1:0] qn_reg, qd_reg, rn_reg, rd_reg, mn_reg, md_reg;
    logic [CNT_W-1:0] bit_reg;
    logic             sn_reg, sd_reg, early_reg;
    logic [WIDTH-1:0] on_reg, od_reg;

    func_t            fn;
    logic [WIDTH-1:0] ln_w, ld_w, rn_w, rd_w;
    logic             zero_case;
    logic [WIDTH-1:0] mul_a, mul_b, prod;
    logic [WIDTH-1:0] an, ad, gsub;
    logic             ga_gt;
    logic [WIDTH:0]   trn, trd;
    logic [WIDTH-1:0] qn_s, qd_s;

    assign fn   = func_t'(func);
    assign ln_w = WIDTH'(signed'(left_numer));
    assign ld_w = WIDTH'(signed'(left_denom));
    assign rn_w = WIDTH'(signed'(right_numer));
    assign rd_w = WIDTH'(signed'(right_denom));

    // operand combinations that give 0/1 straight away
    assign zero_case = (ld_w == '0) ||
                       (((fn == FUNC_ADD) || (fn == FUNC_SUB) || (fn == FUNC_MUL)) &&
                        (rd_w == '0)) ||
                       ((fn == FUNC_DIV) && (rn_w == '0)) ||
                       (fn == FUNC_NONE);

    assign prod = mul_a * mul_b;

    always_comb
    begin
        mul_a = nl_reg;
        mul_b = dr_reg;
        unique case (cmd.op)
            OP_MUL_A:
            begin
                mul_a = nl_reg;
                mul_b = (f_reg == FUNC_MUL) ? nr_reg : dr_reg;
            end
            OP_MUL_B:
            begin
                mul_a = dl_reg;
                mul_b = (f_reg == FUNC_MUL) ? dr_reg : nr_reg;
            end
            OP_MUL_C:
            begin
                mul_a = dl_reg;
                mul_b = dr_reg;
            end
            default: ;
        endcase
    end

    assign an = x_reg[WIDTH-1] ? (~x_reg + 1'b1) : x_reg;
    assign ad = y_reg[WIDTH-1] ? (~y_reg + 1'b1) : y_reg;
    assign ga_gt = (ga_reg > gb_reg);
    assign gsub  = ga_gt ? (ga_reg - gb_reg) : (gb_reg - ga_reg);
    assign trn = {rn_reg, mn_reg[WIDTH-1]} - {1'b0, g_reg};
    assign trd = {rd_reg, md_reg[WIDTH-1]} - {1'b0, g_reg};
    assign qn_s = sn_reg ? (~qn_reg + 1'b1) : qn_reg;
    assign qd_s = sd_reg ? (~qd_reg + 1'b1) : qd_reg;

    assign sts.gcd_done = (ga_reg == gb_reg);
    assign sts.div_done = (bit_reg == CNT_W'(WIDTH));
    assign sts.early    = early_reg;
    assign sts.one_mul  = (f_reg == FUNC_MUL) || (f_reg == FUNC_DIV);
    assign sts.two_mul  = ((f_reg == FUNC_ADD) || (f_reg == FUNC_SUB)) && (dl_reg != dr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nl_reg    <= '0;
            dl_reg    <= '0;
            nr_reg    <= '0;
            dr_reg    <= '0;
            f_reg     <= FUNC_ADD;
            x_reg     <= '0;
            y_reg     <= '0;
            ga_reg    <= '0;
            gb_reg    <= '0;
            sh_reg    <= '0;
            g_reg     <= '0;
            qn_reg    <= '0;
            qd_reg    <= '0;
            rn_reg    <= '0;
            rd_reg    <= '0;
            mn_reg    <= '0;
            md_reg    <= '0;
            bit_reg   <= '0;
            sn_reg    <= 1'b0;
            sd_reg    <= 1'b0;
            early_reg <= 1'b0;
            on_reg    <= '0;
            od_reg    <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_LOAD:
                begin
                    nl_reg <= ln_w;
                    dl_reg <= ld_w;
                    nr_reg <= rn_w;
                    dr_reg <= rd_w;
                    f_reg  <= fn;
                    y_reg  <= ld_w;
                    unique case (fn)
                        FUNC_ADD: x_reg <= ln_w + rn_w;
                        FUNC_SUB: x_reg <= ln_w - rn_w;
                        FUNC_NEG: x_reg <= -ln_w;
                        default:  x_reg <= ln_w;
                    endcase
                    early_reg <= zero_case || (fn == FUNC_QUICK);
                    if (zero_case)
                    begin
                        on_reg <= '0;
                        od_reg <= WIDTH'(1);
                    end
                    else if (fn == FUNC_QUICK)
                    begin
                        on_reg <= ld_w[WIDTH-1] ? -ln_w : ln_w;
                        od_reg <= ld_w[WIDTH-1] ? -ld_w : ld_w;
                    end
                end
                OP_MUL_A: x_reg <= prod;
                OP_MUL_B:
                begin
                    unique case (f_reg)
                        FUNC_ADD: x_reg <= x_reg + prod;
                        FUNC_SUB: x_reg <= x_reg - prod;
                        default:  y_reg <= prod;
                    endcase
                end
                OP_MUL_C: y_reg <= prod;
                OP_PREP:
                begin
                    if ((x_reg == '0) || (y_reg == '0))
                    begin
                        early_reg <= 1'b1;
                        on_reg <= '0;
                        od_reg <= WIDTH'(1);
                    end
                    ga_reg <= an;
                    gb_reg <= ad;
                    sh_reg <= '0;
                    mn_reg <= an;
                    md_reg <= ad;
                    sn_reg <= x_reg[WIDTH-1];
                    sd_reg <= y_reg[WIDTH-1];
                end
                OP_GCD:
                begin
                    // halve evens; both odd: larger becomes half their difference
                    priority if (!ga_reg[0] && !gb_reg[0])
                    begin
                        ga_reg <= ga_reg >> 1;
                        gb_reg <= gb_reg >> 1;
                        sh_reg <= sh_reg + 1'b1;
                    end
                    else if (!ga_reg[0])
                        ga_reg <= ga_reg >> 1;
                    else if (!gb_reg[0])
                        gb_reg <= gb_reg >> 1;
                    else if (ga_gt)
                        ga_reg <= gsub >> 1;
                    else
                        gb_reg <= gsub >> 1;
                end
                OP_DIVS:
                begin
                    if (cmd.div_init)
                    begin
                        g_reg <= ga_reg << sh_reg;
                        bit_reg <= '0;
                        rn_reg <= '0;
                        rd_reg <= '0;
                    end
                    else
                    begin
                        rn_reg <= trn[WIDTH] ? {rn_reg[WIDTH-2:0], mn_reg[WIDTH-1]}
                                             : trn[WIDTH-1:0];
                        rd_reg <= trd[WIDTH] ? {rd_reg[WIDTH-2:0], md_reg[WIDTH-1]}
                                             : trd[WIDTH-1:0];
                        qn_reg <= {qn_reg[WIDTH-2:0], ~trn[WIDTH]};
                        qd_reg <= {qd_reg[WIDTH-2:0], ~trd[WIDTH]};
                        mn_reg <= {mn_reg[WIDTH-2:0], 1'b0};
                        md_reg <= {md_reg[WIDTH-2:0], 1'b0};
                        bit_reg <= bit_reg + 1'b1;
                    end
                end
                OP_FIX:
                begin
                    on_reg <= qd_s[WIDTH-1] ? -qn_s : qn_s;
                    od_reg <= qd_s[WIDTH-1] ? -qd_s : qd_s;
                end
                default: ;
            endcase
        end
    end

    assign result_numer = 32'(signed'(on_reg));
    assign result_denom = 32'(signed'(od_reg));

endmodule

/* sv/rau_ctrl.sv */
// ---------------------------------------------------------------------------
// rau_ctrl
// sequencer for load, multiply, gcd, divide and output handshake
// ---------------------------------------------------------------------------
module rau_ctrl
    import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_fire,
    input  logic     out_fire,
    input  rau_sts_t sts,
    output rau_cmd_t cmd,
    output logic     busy,
    output logic     out_valid
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_MULA, S_MULB, S_MULC, S_PREP, S_PCHK,
        S_GCD, S_DINIT, S_DIV, S_FIX, S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op = OP_IDLE;
        cmd.div_init = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.op = OP_LOAD;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.early)
                    state_next = S_OUT;
                else if (sts.one_mul || sts.two_mul)
                    state_next = S_MULA;
                else
                    state_next = S_PREP;
            end
            S_MULA:
            begin
                cmd.op = OP_MUL_A;
                state_next = S_MULB;
            end
            S_MULB:
            begin
                cmd.op = OP_MUL_B;
                state_next = sts.two_mul ? S_MULC : S_PREP;
            end
            S_MULC:
            begin
                cmd.op = OP_MUL_C;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.op = OP_PREP;
                state_next = S_PCHK;
            end
            S_PCHK:  state_next = sts.early ? S_OUT : S_GCD;
            S_GCD:
            begin
                if (sts.gcd_done)
                    state_next = S_DINIT;
                else
                    cmd.op = OP_GCD;
            end
            S_DINIT:
            begin
                cmd.op = OP_DIVS;
                cmd.div_init = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_FIX;
                else
                    cmd.op = OP_DIVS;
            end
            S_FIX:
            begin
                cmd.op = OP_FIX;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_fire)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

endmodule

/* bench/rational_arithmetic_unit_test.sv */
// ---------------------------------------------------------------------------
// rational_arithmetic_unit_test
// self-checking bench for the rational arithmetic unit
// ---------------------------------------------------------------------------
// a queue of requests feeds a clocked driver on the slave side; a clocked
// monitor predicts each accepted request into a queue of expected reduced
// fractions and compares every result against the oldest one. directed
// corner cases come first, then random requests with random idling on both
// sides and one pause that drains all outstanding results
// ---------------------------------------------------------------------------
module rational_arithmetic_unit_test
    import rau_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // first field in the lowest bits, as on s_tdata
    typedef struct packed {
        logic [31:0] right_denom;
        logic [31:0] right_numer;
        logic [31:0] left_denom;
        logic [31:0] left_numer;
        func_t       func;
    } request_t;

    // numerator in the lowest bits, as on m_tdata
    typedef struct packed {
        logic [31:0] denom;
        logic [31:0] numer;
    } fraction_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // func[2:0], left_numer[34:3], left_denom[66:35], right_numer[98:67],
    // right_denom[130:99], zero fill to 136
    logic [135:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // result_numer[31:0], result_denom[63:32]
    logic [63:0]  m_tdata;

    request_t  pending_requests[$];
    fraction_t expected_fractions[$];

    int  requests_sent;
    int  fractions_checked;
    int  error_count;
    int  func_seen[8];
    int  send_gap;
    int  recv_gap;
    bit  fire_in;

    rational_arithmetic_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ---------------------------------------------------------------------
    // clock and reset
    // ---------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ---------------------------------------------------------------------
    // predictor: WIDTH-bit two's complement held sign-extended in 64 bits
    // ---------------------------------------------------------------------
    function automatic logic [63:0] wrap_width(logic [63:0] x);
        logic [63:0] mask;
        mask = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - WIDTH);
        x = x & mask;
        if (x[WIDTH-1])
            x = x | ~mask;
        return x;
    endfunction

    function automatic logic [63:0] widen(logic [31:0] x);
        return wrap_width({{32{x[31]}}, x});
    endfunction

    function automatic logic [63:0] negate_width(logic [63:0] x);
        return wrap_width(64'd0 - x);
    endfunction

    function automatic logic [63:0] magnitude(logic [63:0] x);
        return x[63] ? 64'd0 - x : x;
    endfunction

    function automatic logic [63:0] euclid_gcd(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic fraction_t pack_fraction(logic [63:0] n, logic [63:0] d);
        fraction_t f;
        f.numer = n[31:0];
        f.denom = d[31:0];
        return f;
    endfunction

    // divide out the gcd, then force the denominator positive
    function automatic fraction_t reduce_fraction(logic [63:0] n, logic [63:0] d);
        logic [63:0] g;
        logic [63:0] qn;
        logic [63:0] qd;
        if (n == 0 || d == 0)
            return pack_fraction(64'd0, 64'd1);
        g  = euclid_gcd(magnitude(n), magnitude(d));
        qn = magnitude(n) / g;
        qd = magnitude(d) / g;
        qn = n[63] ? negate_width(qn) : wrap_width(qn);
        qd = d[63] ? negate_width(qd) : wrap_width(qd);
        // most negative denominator wraps back onto itself here
        if (qd[63])
        begin
            qn = negate_width(qn);
            qd = negate_width(qd);
        end
        return pack_fraction(qn, qd);
    endfunction

    function automatic fraction_t rational_result(request_t r);
        logic [63:0] nl;
        logic [63:0] dl;
        logic [63:0] nr;
        logic [63:0] dr;
        logic [63:0] cross_a;
        logic [63:0] cross_b;
        nl = widen(r.left_numer);
        dl = widen(r.left_denom);
        nr = widen(r.right_numer);
        dr = widen(r.right_denom);
        case (r.func)
            FUNC_ADD, FUNC_SUB:
            begin
                if (dl == 0 || dr == 0)
                    return pack_fraction(64'd0, 64'd1);
                // shared denominator skips the cross products
                if (dl == dr)
                    return reduce_fraction(wrap_width(r.func == FUNC_ADD ? nl + nr
                                                                         : nl - nr), dl);
                cross_a = nl * dr;
                cross_b = nr * dl;
                return reduce_fraction(wrap_width(r.func == FUNC_ADD ? cross_a + cross_b
                                                                     : cross_a - cross_b),
                                       wrap_width(dl * dr));
            end
            FUNC_MUL:
            begin
                if (dl == 0 || dr == 0)
                    return pack_fraction(64'd0, 64'd1);
                return reduce_fraction(wrap_width(nl * nr), wrap_width(dl * dr));
            end
            FUNC_DIV:
            begin
                if (dl == 0 || nr == 0)
                    return pack_fraction(64'd0, 64'd1);
                return reduce_fraction(wrap_width(nl * dr), wrap_width(dl * nr));
            end
            FUNC_CANON:
                return reduce_fraction(nl, dl);
            FUNC_QUICK:
            begin
                // sign fix only, no gcd
                if (dl == 0)
                    return pack_fraction(64'd0, 64'd1);
                if (dl[63])
                    return pack_fraction(negate_width(nl), negate_width(dl));
                return pack_fraction(nl, dl);
            end
            FUNC_NEG:
                return reduce_fraction(negate_width(nl), dl);
            default:
                return pack_fraction(64'd0, 64'd1);
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------
    task automatic queue_request(func_t f, logic [31:0] ln, logic [31:0] ld,
                                 logic [31:0] rn, logic [31:0] rd);
        request_t r;
        r.func        = f;
        r.left_numer  = ln;
        r.left_denom  = ld;
        r.right_numer = rn;
        r.right_denom = rd;
        pending_requests.push_back(r);
    endtask

    // mostly small values so that gcds are non-trivial, some full range
    function automatic logic [31:0] random_operand();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return $unsigned($urandom_range(0, 120)) - 32'd60;
        if (pick < 60)
            return $unsigned($urandom_range(0, 2000)) * $unsigned($urandom_range(1, 12))
                   - 32'd12000;
        if (pick < 70)
            return {{16{1'b0}}, 16'($urandom)} ^ ({32{1'($urandom)}});
        if (pick < 76)
        begin
            case ($urandom_range(0, 5))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                3:       return 32'hFFFF_FFFF;
                4:       return 32'h0001_0000;
                default: return 32'h0000_0001;
            endcase
        end
        return $urandom;
    endfunction

    // mostly short gaps, the odd long one
    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    initial
    begin
        logic [31:0] ld;
        logic [31:0] rd;
        int          f;
        // directed corners
        queue_request(FUNC_ADD,   32'd1, 32'd2, 32'd1, 32'd3);
        queue_request(FUNC_ADD,   32'd3, 32'd6, 32'd5, 32'd6);         // shared denominator
        queue_request(FUNC_SUB,   32'd5, 32'd7, 32'd5, 32'd7);         // zero difference
        queue_request(FUNC_SUB,   32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'd3);
        queue_request(FUNC_ADD,   32'd1, 32'd0, 32'd1, 32'd2);         // zero left denominator
        queue_request(FUNC_SUB,   32'd1, 32'd2, 32'd1, 32'd0);         // zero right denominator
        queue_request(FUNC_MUL,   32'd4, 32'd9, 32'd3, 32'd8);
        queue_request(FUNC_MUL,   32'd1, 32'h0001_0000, 32'd1, 32'h0001_0000); // wrapped zero
        queue_request(FUNC_MUL,   32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        queue_request(FUNC_DIV,   32'd2, 32'd3, 32'd0, 32'd5);         // divide by zero
        queue_request(FUNC_DIV,   32'd2, 32'd0, 32'd4, 32'd5);
        queue_request(FUNC_DIV,   32'hFFFF_FFFA, 32'd7, 32'd3, 32'hFFFF_FFF2);
        queue_request(FUNC_CANON, 32'd12, 32'hFFFF_FFF8, 32'd0, 32'd0);
        queue_request(FUNC_CANON, 32'd0, 32'd5, 32'd0, 32'd0);
        queue_request(FUNC_CANON, 32'd1, 32'h8000_0000, 32'd0, 32'd0); // most negative denom
        queue_request(FUNC_CANON, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(FUNC_QUICK, 32'd0, 32'd5, 32'd0, 32'd0);         // stays 0/5
        queue_request(FUNC_QUICK, 32'd6, 32'hFFFF_FFFC, 32'd1, 32'd1);
        queue_request(FUNC_QUICK, 32'd6, 32'd0, 32'd1, 32'd1);
        queue_request(FUNC_QUICK, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
        queue_request(FUNC_NEG,   32'h8000_0000, 32'd1, 32'd0, 32'd0);
        queue_request(FUNC_NEG,   32'd10, 32'hFFFF_FFFC, 32'd0, 32'd0);
        queue_request(FUNC_NONE,  32'd3, 32'd4, 32'd5, 32'd6);
        queue_request(FUNC_NONE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // random part
        repeat (925)
        begin
            ld = random_operand();
            rd = ($urandom_range(0, 4) == 0) ? ld : random_operand();
            f  = ($urandom_range(0, 29) == 0) ? 7 : $urandom_range(0, 6);
            queue_request(func_t'(f), random_operand(), ld, random_operand(), rd);
        end
    end

    // ---------------------------------------------------------------------
    // driver: slave side updates at the falling edge
    // ---------------------------------------------------------------------
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end
        else if (!s_tvalid || fire_in)
        begin
            if (fire_in)
                send_gap <= random_gap();
            // drain everything once after the first 300 requests
            if (send_gap > 0 && !fire_in)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_requests.size() == 0
                     || (requests_sent == 300 && expected_fractions.size() != 0)
                     || (fire_in && random_gap() > 0))
                s_tvalid <= 1'b0;
            else
            begin
                s_tdata  <= {5'd0, pending_requests.pop_front()};
                s_tvalid <= 1'b1;
            end
        end
    end

    // master side back-pressure, with a no-stall stretch every so often
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!((fractions_checked / 100) % 3 == 1))
                recv_gap <= random_gap();
        end
    end

    // ---------------------------------------------------------------------
    // monitor: predict accepted requests, check results at the rising edge
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        request_t  req;
        fraction_t got;
        fraction_t want;
        if (!rst_n)
        begin
            fire_in           <= 1'b0;
            requests_sent     = 0;
            fractions_checked = 0;
            error_count       = 0;
        end
        else
        begin
            fire_in <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                fractions_checked++;
                if (expected_fractions.size() == 0)
                begin
                    $display("%0t: unexpected result %0d/%0d", $time,
                             $signed(got.numer), $signed(got.denom));
                    error_count++;
                end
                else
                begin
                    want = expected_fractions.pop_front();
                    if (got.numer !== want.numer)
                    begin
                        $display("%0t: result_numer expected %0d actual %0d", $time,
                                 $signed(want.numer), $signed(got.numer));
                        error_count++;
                    end
                    if (got.denom !== want.denom)
                    begin
                        $display("%0t: result_denom expected %0d actual %0d", $time,
                                 $signed(want.denom), $signed(got.denom));
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                req = s_tdata[130:0];
                expected_fractions.push_back(rational_result(req));
                func_seen[req.func]++;
                requests_sent++;
            end
        end
    end

    // ---------------------------------------------------------------------
    // end of run
    // ---------------------------------------------------------------------
    initial
    begin
        wait (rst_n === 1'b1);
        wait (pending_requests.size() == 0 && !s_tvalid && expected_fractions.size() == 0);
        repeat (300) @(posedge clk);
        $display("%0d requests, %0d results; add %0d sub %0d mul %0d div %0d", requests_sent,
                 fractions_checked, func_seen[0], func_seen[1], func_seen[2], func_seen[3]);
        $display("canon %0d quick %0d neg %0d unused code %0d, %0d mismatches", func_seen[4],
                 func_seen[5], func_seen[6], func_seen[7], error_count);
        if (error_count == 0 && expected_fractions.size() == 0)
            $display("[rational_arithmetic_unit] OK");
        else
            $display("[rational_arithmetic_unit] ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("%0t: timeout with %0d results outstanding", $time, expected_fractions.size());
        $display("[rational_arithmetic_unit] ERROR");
        $finish;
    end

endmodule
